// ===== hdl/ghe_pkg.sv =====
`default_nettype none

package ghe_pkg;

  // pixel and result widths are fixed by the stream format
  localparam int PIX_W   = 8;
  localparam int OUT_W   = 8;
  localparam int OUT_MAX = 255;

  // defaults for the top-level parameters
  localparam int BINS_DEF        = 256;
  localparam int COUNT_WIDTH_DEF = 21;

  // op field codes
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/ghe_ram.sv =====
`default_nettype none

module ghe_ram #(
  parameter int W = 8,
  parameter int D = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/global_histogram_equalizer.sv =====
// Count item: bin read, then saturating write-back; the block is busy meanwhile.
// Map item: table RAM read, then out_valid rises once the output slot is free; busy meanwhile.
// Last count item adds a table build: pass 1 reads each bin to total the histogram,
// then per bin a read, a cumulate/clear and 8 steps of the shared restoring divider.
// rst_n (sync, active low) starts a histogram clearing pass; in_ready stays low
// until it ends. Map items before the first build return 0.
`default_nettype none

module global_histogram_equalizer
  import ghe_pkg::*;
#(
  parameter int BINS        = BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_op,
  input  wire logic [PIX_W-1:0] in_pixel,
  input  wire logic             in_last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [OUT_W-1:0] out_mapped_pixel
);

  localparam int AW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CW  = COUNT_WIDTH;
  localparam int NW  = CW + OUT_W;          // numerator cum * 255
  localparam int SW  = $clog2(OUT_W);       // divider step counter
  localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(OUT_W - 1);

  // sequencer states
  localparam logic [3:0] S_CLR     = 4'd0;  // clearing pass after reset
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_INC     = 4'd2;  // bin read back, write +1
  localparam logic [3:0] S_MAP     = 4'd3;  // table data ready, wait for out slot
  localparam logic [3:0] S_SUM_RD  = 4'd4;  // pass 1: read bin
  localparam logic [3:0] S_SUM_ACC = 4'd5;  // pass 1: accumulate total
  localparam logic [3:0] S_BLD_RD  = 4'd6;  // pass 2: read bin
  localparam logic [3:0] S_BLD_CUM = 4'd7;  // pass 2: cumulate, clear bin
  localparam logic [3:0] S_DIV     = 4'd8;  // pass 2: divider steps

  // control registers
  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          built_r, built_nxt;
  logic          out_valid_r, out_valid_nxt;

  // datapath registers
  logic [AW-1:0]    bin_r, bin_nxt;
  logic             last_r, last_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic [CW-1:0]    run_r, run_nxt;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    den_r, den_nxt;
  logic [OUT_W-1:0] quo_r, quo_nxt;
  logic [OUT_W-1:0] out_pix_r, out_pix_nxt;

  // memory ports
  logic             hist_we, hist_re;
  logic [AW-1:0]    hist_waddr, hist_raddr;
  logic [CW-1:0]    hist_wdata, hist_rdata;
  logic             tbl_we, tbl_re;
  logic [AW-1:0]    tbl_waddr, tbl_raddr;
  logic [OUT_W-1:0] tbl_wdata, tbl_rdata;

  logic [AW-1:0]    in_bin;
  logic [CW:0]      acc_sum;     // saturating adder sum, one spare bit
  logic [CW-1:0]    acc_sat;
  logic [CW-1:0]    cum_sat;
  logic [NW-1:0]    cum_ext;
  logic             div_ge;
  logic [OUT_W-1:0] quo_next_bits;
  logic             out_free;

  ghe_ram #(.W(CW), .D(BINS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  ghe_ram #(.W(OUT_W), .D(BINS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // pixels past the last bin land in the last bin
  always_comb begin
    if (32'(in_pixel) > 32'(BINS - 1)) begin
      in_bin = LAST_BIN;
    end else begin
      in_bin = AW'(in_pixel);
    end
  end

  // one saturating adder: total in pass 1, running sum in pass 2
  always_comb begin
    if (state_r == S_SUM_ACC) begin
      acc_sum = {1'b0, total_r} + {1'b0, hist_rdata};
    end else begin
      acc_sum = {1'b0, run_r} + {1'b0, hist_rdata};
    end
    acc_sat = acc_sum[CW] ? {CW{1'b1}} : acc_sum[CW-1:0];
    cum_sat = acc_sat;
    cum_ext = NW'(cum_sat);
  end

  // restoring divider step: one quotient bit per cycle, MSB first
  assign div_ge        = (rem_r >= den_r);
  assign quo_next_bits = {quo_r[OUT_W-2:0], div_ge};

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    built_nxt     = built_r;
    out_valid_nxt = out_valid_r && !out_ready;
    bin_nxt       = bin_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    run_nxt       = run_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    out_pix_nxt   = out_pix_r;

    hist_we    = 1'b0;
    hist_waddr = idx_r;
    hist_wdata = '0;
    hist_re    = 1'b0;
    hist_raddr = idx_r;
    tbl_we     = 1'b0;
    tbl_waddr  = idx_r;
    tbl_wdata  = quo_next_bits;
    tbl_re     = 1'b0;
    tbl_raddr  = in_bin;
    in_ready   = 1'b0;

    case (state_r)
      S_CLR: begin
        hist_we = 1'b1;
        if (idx_r == LAST_BIN) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bin_nxt  = in_bin;
          last_nxt = in_last;
          if (in_op == OP_MAP) begin
            tbl_re    = 1'b1;
            state_nxt = S_MAP;
          end else begin
            hist_re    = 1'b1;
            hist_raddr = in_bin;
            state_nxt  = S_INC;
          end
        end
      end
      S_INC: begin
        hist_we    = 1'b1;
        hist_waddr = bin_r;
        hist_wdata = (&hist_rdata) ? hist_rdata : hist_rdata + 1'b1;
        if (last_r) begin
          idx_nxt   = '0;
          total_nxt = '0;
          state_nxt = S_SUM_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MAP: begin
        // table read data holds until the next read
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = built_r ? tbl_rdata : '0;
          state_nxt     = S_IDLE;
        end
      end
      S_SUM_RD: begin
        hist_re   = 1'b1;
        state_nxt = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        total_nxt = acc_sat;
        if (idx_r == LAST_BIN) begin
          idx_nxt   = '0;
          run_nxt   = '0;
          state_nxt = S_BLD_RD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SUM_RD;
        end
      end
      S_BLD_RD: begin
        hist_re   = 1'b1;
        state_nxt = S_BLD_CUM;
      end
      S_BLD_CUM: begin
        // bin is cleared for the next frame as it is consumed
        hist_we   = 1'b1;
        run_nxt   = cum_sat;
        rem_nxt   = (cum_ext << OUT_W) - cum_ext;
        den_nxt   = NW'(total_r) << (OUT_W - 1);
        quo_nxt   = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = div_ge ? rem_r - den_r : rem_r;
        den_nxt  = den_r >> 1;
        quo_nxt  = quo_next_bits;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          tbl_we    = 1'b1;
          tbl_wdata = (total_r == '0) ? '0 : quo_next_bits;
          if (idx_r == LAST_BIN) begin
            idx_nxt   = '0;
            run_nxt   = '0;
            built_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_BLD_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      step_r      <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    last_r    <= last_nxt;
    total_r   <= total_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    quo_r     <= quo_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = out_pix_r;

`ifndef NO_ASSERTIONS
  // a count beat never produces a result beat
  a_count_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_COUNT) |=> !$rose(out_valid))
    else $error("result raised by count beat");

  // cumulative sum cannot pass the frame total during the build
  a_run_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (run_r <= total_r))
    else $error("running sum above total");

  // divider remainder stays below twice the current divisor
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && total_r != '0) |-> ({1'b0, rem_r} < {den_r, 1'b0}))
    else $error("divider remainder out of range");

  // build ends with the running sum back at zero
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == LAST_STEP && idx_r == LAST_BIN) |=>
      (run_r == '0 && built_r))
    else $error("build did not finish cleanly");
`endif

endmodule

`default_nettype wire
